[design/max_pool_1d_with_argmax_unit_defines.svh]
// Assertion macros for the checker file.
`ifndef MAX_POOL_1D_WITH_ARGMAX_UNIT_DEFINES_SVH
`define MAX_POOL_1D_WITH_ARGMAX_UNIT_DEFINES_SVH

// Check a property on every clock edge, reset included.
`define MPA_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

// Check a property outside reset.
`define MPA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

[design/mpa_pkg.sv]
`default_nettype none

package mpa_pkg;

   // Sample buffer depth, also the largest window
   localparam int MAX_WINDOW   = 16;
   localparam int WIN_IDX_BITS = $clog2(MAX_WINDOW);
   localparam int OFFSET_BITS  = 4;

   // Defaults for the top level parameters
   localparam int MAX_ROW_DEFAULT     = 65536;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   // Register file
   localparam int LENGTH_BITS    = 5;
   localparam int STEP_BITS      = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 8;
   localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 5'd2;
   localparam logic [STEP_BITS-1:0]   STEP_RESET   = 8'd2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_LENGTH = 2'd0,
      CSR_WINDOW_STEP   = 2'd1
   } csr_index_type;

   // Output counters and positions
   localparam int COUNT_BITS = 16;

   // Decoupling queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Classification of one accepted word, handed from front to back
   typedef struct packed {
      logic                    store;
      logic                    hit;
      logic                    eor;
      logic [COUNT_BITS-1:0]   start;
      logic [COUNT_BITS-1:0]   win_num;
      logic [WIN_IDX_BITS-1:0] len_m1;
      logic [WIN_IDX_BITS-1:0] wp;
   } ctrl_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_SCAN,
      BACK_DRAIN
   } back_state_type;

endpackage

`default_nettype wire

[design/mpa_front.sv]
`default_nettype none

module mpa_front #(
   parameter int MAX_ROW = mpa_pkg::MAX_ROW_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   input  wire logic                               req_end_of_row,
   input  wire logic                               q_full,
   input  wire logic                               csr_valid,
   input  wire logic [mpa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [mpa_pkg::CSR_DATA_BITS-1:0]  csr_data,
   output logic                                    enq,
   output mpa_pkg::ctrl_type                       ctrl
);

   localparam int POS_BITS = $clog2(MAX_ROW) + 1;

   logic [mpa_pkg::LENGTH_BITS-1:0] length_ff;
   logic [mpa_pkg::STEP_BITS-1:0]   step_ff;
   logic [POS_BITS-1:0]             pos_ff, pos_in;
   logic [POS_BITS-1:0]             nws_ff, nws_in;
   logic [mpa_pkg::COUNT_BITS-1:0]  wdone_ff, wdone_in;

   logic [mpa_pkg::LENGTH_BITS-1:0] len;
   logic [mpa_pkg::STEP_BITS-1:0]   step;
   logic [POS_BITS:0]               target;
   logic                            in_range;
   logic                            hit;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= mpa_pkg::LENGTH_RESET;
         step_ff   <= mpa_pkg::STEP_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            mpa_pkg::CSR_WINDOW_LENGTH: length_ff <= csr_data[mpa_pkg::LENGTH_BITS-1:0];
            mpa_pkg::CSR_WINDOW_STEP:   step_ff   <= csr_data[mpa_pkg::STEP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Clamp length and step to their usable ranges
   always_comb begin
      if (length_ff == '0)
         len = mpa_pkg::LENGTH_BITS'(1);
      else if (length_ff > mpa_pkg::LENGTH_BITS'(mpa_pkg::MAX_WINDOW))
         len = mpa_pkg::LENGTH_BITS'(mpa_pkg::MAX_WINDOW);
      else
         len = length_ff;
      step = (step_ff == '0) ? mpa_pkg::STEP_BITS'(1) : step_ff;
   end

   // Classify the word: stored, and whether it closes a window
   assign enq      = req_push && !q_full;
   assign in_range = pos_ff < POS_BITS'(MAX_ROW);
   assign target   = {1'b0, nws_ff} + (POS_BITS + 1)'(len) - (POS_BITS + 1)'(1);
   assign hit      = in_range && ({1'b0, pos_ff} == target);

   always_comb begin
      ctrl.store   = in_range;
      ctrl.hit     = hit;
      ctrl.eor     = req_end_of_row;
      ctrl.start   = mpa_pkg::COUNT_BITS'(nws_ff);
      ctrl.win_num = wdone_ff;
      ctrl.len_m1  = mpa_pkg::WIN_IDX_BITS'(len - mpa_pkg::LENGTH_BITS'(1));
      ctrl.wp      = pos_ff[mpa_pkg::WIN_IDX_BITS-1:0];
   end

   // Advance row position, next window start and window count
   always_comb begin
      pos_in   = pos_ff;
      nws_in   = nws_ff;
      wdone_in = wdone_ff;
      if (enq) begin
         if (in_range)
            pos_in = pos_ff + POS_BITS'(1);
         if (hit) begin
            nws_in   = nws_ff + POS_BITS'(step);
            wdone_in = wdone_ff + mpa_pkg::COUNT_BITS'(1);
         end
         if (req_end_of_row) begin
            pos_in   = '0;
            nws_in   = '0;
            wdone_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         nws_ff   <= '0;
         wdone_ff <= '0;
      end else begin
         pos_ff   <= pos_in;
         nws_ff   <= nws_in;
         wdone_ff <= wdone_in;
      end
   end

endmodule

`default_nettype wire

[design/mpa_queue.sv]
`default_nettype none

module mpa_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] din,
   input  wire logic             pop,
   output logic                  full,
   output logic                  empty,
   output logic [WIDTH-1:0]      dout
);

   localparam int PTR_BITS = $clog2(mpa_pkg::QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(mpa_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [mpa_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                do_push, do_pop;

   assign full    = count_ff == CNT_BITS'(mpa_pkg::QUEUE_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   // Hold queued words
   always_ff @(posedge clock) begin
      if (do_push)
         slot_ff[wr_ptr_ff] <= din;
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push)
            wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         if (do_pop)
            rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         if (do_push && !do_pop)
            count_ff <= count_ff + CNT_BITS'(1);
         else if (do_pop && !do_push)
            count_ff <= count_ff - CNT_BITS'(1);
      end
   end

endmodule

`default_nettype wire

[design/mpa_back.sv]
`default_nettype none

module mpa_back #(
   parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 q_empty,
   input  wire mpa_pkg::ctrl_type                    q_ctrl,
   input  wire logic signed [SAMPLE_BITS-1:0]        q_sample,
   output logic                                      q_pop,
   input  wire logic                                 rsp_pop,
   output logic                                      rsp_empty,
   output logic signed [SAMPLE_BITS-1:0]             rsp_max_value,
   output logic [mpa_pkg::OFFSET_BITS-1:0]           rsp_max_offset,
   output logic [mpa_pkg::COUNT_BITS-1:0]            rsp_max_position,
   output logic [mpa_pkg::COUNT_BITS-1:0]            rsp_window_number,
   output logic                                      rsp_last_window
);

   localparam int IB = mpa_pkg::WIN_IDX_BITS;

   mpa_pkg::back_state_type state_ff, state_in;

   logic signed [SAMPLE_BITS-1:0] buf_mem [mpa_pkg::MAX_WINDOW];

   mpa_pkg::ctrl_type             job_ff, job_in;
   logic [IB-1:0]                 k_ff, k_in;
   logic [IB-1:0]                 rd_addr;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic                          rd_vld_ff;
   logic [IB-1:0]                 rd_off_ff;
   logic signed [SAMPLE_BITS-1:0] best_ff, best_in;
   logic [IB-1:0]                 best_off_ff, best_off_in;
   logic                          take;
   logic                          wr_en, issue, load_out, out_free;
   logic                          out_vld_ff;

   // Sample buffer: write on pop of a stored word, registered read for the scan
   assign rd_addr = job_ff.start[IB-1:0] + k_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         buf_mem[q_ctrl.wp] <= q_sample;
      rd_data_ff <= buf_mem[rd_addr];
   end

   // Sequence words: pop, scan the window, hand over the result
   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      k_in     = k_ff;
      q_pop    = 1'b0;
      wr_en    = 1'b0;
      issue    = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         mpa_pkg::BACK_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               wr_en = q_ctrl.store;
               if (q_ctrl.hit) begin
                  job_in   = q_ctrl;
                  k_in     = '0;
                  state_in = mpa_pkg::BACK_SCAN;
               end
            end
         end
         mpa_pkg::BACK_SCAN: begin
            issue = 1'b1;
            if (k_ff == job_ff.len_m1)
               state_in = mpa_pkg::BACK_DRAIN;
            else
               k_in = k_ff + IB'(1);
         end
         mpa_pkg::BACK_DRAIN: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = mpa_pkg::BACK_IDLE;
            end
         end
         default: state_in = mpa_pkg::BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset)
         state_ff <= mpa_pkg::BACK_IDLE;
      else
         state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      k_ff   <= k_in;
   end

   // Running maximum; a later sample wins only when strictly larger
   assign take        = rd_vld_ff && ((rd_off_ff == '0) || (rd_data_ff > best_ff));
   assign best_in     = take ? rd_data_ff : best_ff;
   assign best_off_in = take ? rd_off_ff : best_off_ff;

   always_ff @(posedge clock) begin
      if (reset)
         rd_vld_ff <= 1'b0;
      else
         rd_vld_ff <= issue;
      rd_off_ff   <= k_ff;
      best_ff     <= best_in;
      best_off_ff <= best_off_in;
   end

   // Result register
   assign out_free  = !out_vld_ff || rsp_pop;
   assign rsp_empty = !out_vld_ff;

   always_ff @(posedge clock) begin
      if (reset)
         out_vld_ff <= 1'b0;
      else if (load_out)
         out_vld_ff <= 1'b1;
      else if (rsp_pop)
         out_vld_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_max_value     <= best_in;
         rsp_max_offset    <= mpa_pkg::OFFSET_BITS'(best_off_in);
         rsp_max_position  <= job_ff.start + mpa_pkg::COUNT_BITS'(best_off_in);
         rsp_window_number <= job_ff.win_num;
         rsp_last_window   <= job_ff.eor;
      end
   end

endmodule

`default_nettype wire

[design/max_pool_1d_with_argmax_unit.sv]
// One-dimensional max pooling with argmax over a stream of signed samples, one sample
// per word, end_of_row closing the row. A window of window_length samples (0 taken as 1,
// above 16 taken as 16) starts every window_step samples (0 taken as 1); the sample that
// closes a window yields its maximum, the offset and row position of the first maximal
// sample, the window number and whether it closed the row. Partial windows at the end of a
// row yield nothing, and samples at row positions MAX_ROW and beyond are dropped. The input
// side takes one word per cycle, while the queue is not full, into a four-word queue. The
// back end scans each window that a word closes through the single read port of its sample
// buffer, one sample per cycle, and pops no new word until that window's result is handed
// over. Registers must be written through the csr_ port only while the block is idle; the
// block itself does not enforce this. csr_ready is always high and unknown indexes are
// ignored.
`default_nettype none

module max_pool_1d_with_argmax_unit #(
   parameter int MAX_ROW     = mpa_pkg::MAX_ROW_DEFAULT,
   parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   output logic                                    req_full,
   input  wire logic signed [SAMPLE_BITS-1:0]      req_sample,
   input  wire logic                               req_end_of_row,
   output logic                                    rsp_empty,
   input  wire logic                               rsp_pop,
   output logic signed [SAMPLE_BITS-1:0]           rsp_max_value,
   output logic [mpa_pkg::OFFSET_BITS-1:0]         rsp_max_offset,
   output logic [mpa_pkg::COUNT_BITS-1:0]          rsp_max_position,
   output logic [mpa_pkg::COUNT_BITS-1:0]          rsp_window_number,
   output logic                                    rsp_last_window,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [mpa_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [mpa_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int CTRL_BITS = $bits(mpa_pkg::ctrl_type);
   localparam int Q_WIDTH   = SAMPLE_BITS + CTRL_BITS;

   logic                          enq;
   mpa_pkg::ctrl_type             f_ctrl, q_ctrl;
   logic                          q_full, q_empty, q_pop;
   logic [Q_WIDTH-1:0]            q_din, q_dout;
   logic signed [SAMPLE_BITS-1:0] q_sample;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;

   // Classify incoming words
   mpa_front #(
      .MAX_ROW (MAX_ROW)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_end_of_row (req_end_of_row),
      .q_full         (q_full),
      .csr_valid      (csr_valid),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .enq            (enq),
      .ctrl           (f_ctrl)
   );

   // Decouple front and back
   assign q_din    = {req_sample, f_ctrl};
   assign q_sample = q_dout[Q_WIDTH-1:CTRL_BITS];
   assign q_ctrl   = q_dout[CTRL_BITS-1:0];

   mpa_queue #(
      .WIDTH (Q_WIDTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (enq),
      .din   (q_din),
      .pop   (q_pop),
      .full  (q_full),
      .empty (q_empty),
      .dout  (q_dout)
   );

   // Store samples, scan windows, deliver results
   mpa_back #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty           (q_empty),
      .q_ctrl            (q_ctrl),
      .q_sample          (q_sample),
      .q_pop             (q_pop),
      .rsp_pop           (rsp_pop),
      .rsp_empty         (rsp_empty),
      .rsp_max_value     (rsp_max_value),
      .rsp_max_offset    (rsp_max_offset),
      .rsp_max_position  (rsp_max_position),
      .rsp_window_number (rsp_window_number),
      .rsp_last_window   (rsp_last_window)
   );

endmodule

`default_nettype wire

[design/mpa_checker.sv]
`default_nettype none
`include "max_pool_1d_with_argmax_unit_defines.svh"

module mpa_checker #(
   parameter int SAMPLE_BITS = mpa_pkg::SAMPLE_BITS_DEFAULT
) (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_full,
   input wire logic                               rsp_empty,
   input wire logic                               rsp_pop,
   input wire logic signed [SAMPLE_BITS-1:0]      rsp_max_value,
   input wire logic [mpa_pkg::OFFSET_BITS-1:0]    rsp_max_offset,
   input wire logic [mpa_pkg::COUNT_BITS-1:0]     rsp_max_position,
   input wire logic [mpa_pkg::COUNT_BITS-1:0]     rsp_window_number,
   input wire logic                               rsp_last_window,
   input wire logic                               csr_ready
);

   // Reset leaves no result waiting and the queue open
   `MPA_ASSERT_ALWAYS(a_reset_state, clock, reset |=> (rsp_empty && !req_full), "bad state after reset")

   // A waiting result holds until taken
   `MPA_ASSERT(a_result_hold, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_max_value) && $stable(rsp_max_offset) && $stable(rsp_max_position) && $stable(rsp_window_number) && $stable(rsp_last_window)), "waiting result changed")

   // Register writes are never stalled
   `MPA_ASSERT_ALWAYS(a_csr_ready, clock, csr_ready, "csr_ready dropped")

endmodule

bind max_pool_1d_with_argmax_unit mpa_checker #(
   .SAMPLE_BITS (SAMPLE_BITS)
) u_checker (.*);

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

   localparam int SAMPLE_W       = mpa_pkg::SAMPLE_BITS_DEFAULT;
   localparam int ROW_LIMIT      = mpa_pkg::MAX_ROW_DEFAULT;
   localparam int RESET_CYCLES   = 6;
   localparam int DRAIN_CYCLES   = 120;
   localparam int HOLD_CYCLES    = 300;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 500;

   // Register indexes that decode to nothing
   localparam logic [mpa_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [mpa_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct {
      logic signed [SAMPLE_W-1:0]       max_value;
      logic [mpa_pkg::OFFSET_BITS-1:0]  max_offset;
      logic [mpa_pkg::COUNT_BITS-1:0]   max_position;
      logic [mpa_pkg::COUNT_BITS-1:0]   window_number;
      logic                             last_window;
   } pool_result_type;

   // Window tracker: mirrors the pooling state and queues the windows due
   class pool_scoreboard_type;
      logic [mpa_pkg::LENGTH_BITS-1:0] win_len;
      logic [mpa_pkg::STEP_BITS-1:0]   win_step;
      logic signed [SAMPLE_W-1:0]      recent [mpa_pkg::MAX_WINDOW];
      int unsigned                     row_pos;
      int unsigned                     next_start;
      logic [mpa_pkg::COUNT_BITS-1:0]  windows_done;
      pool_result_type                 pending_windows [$];
      int                              fail_count;

      function new();
         win_len      = mpa_pkg::LENGTH_RESET;
         win_step     = mpa_pkg::STEP_RESET;
         row_pos      = 0;
         next_start   = 0;
         windows_done = '0;
         fail_count   = 0;
         foreach (recent[i]) recent[i] = '0;
      endfunction

      function void note_setting(logic [mpa_pkg::CSR_INDEX_BITS-1:0] idx,
                                 logic [mpa_pkg::CSR_DATA_BITS-1:0] data);
         if (idx == mpa_pkg::CSR_WINDOW_LENGTH) win_len = data[mpa_pkg::LENGTH_BITS-1:0];
         else if (idx == mpa_pkg::CSR_WINDOW_STEP) win_step = data[mpa_pkg::STEP_BITS-1:0];
      endfunction

      function void note_sample(logic signed [SAMPLE_W-1:0] sample, logic eor);
         int unsigned        len;
         int unsigned        step;
         int unsigned        start;
         int unsigned        best_off;
         logic signed [SAMPLE_W-1:0] best;
         pool_result_type    win;
         if (row_pos < ROW_LIMIT) begin
            len  = (win_len == 0) ? 1 : ((win_len > mpa_pkg::MAX_WINDOW) ?
                                         mpa_pkg::MAX_WINDOW : win_len);
            step = (win_step == 0) ? 1 : win_step;
            recent[row_pos % mpa_pkg::MAX_WINDOW] = sample;
            // Close the window on its last sample; ties keep the earliest
            if (row_pos == next_start + len - 1) begin
               start    = next_start;
               best     = recent[start % mpa_pkg::MAX_WINDOW];
               best_off = 0;
               for (int unsigned k = 1; k < len; k++) begin
                  if (recent[(start + k) % mpa_pkg::MAX_WINDOW] > best) begin
                     best     = recent[(start + k) % mpa_pkg::MAX_WINDOW];
                     best_off = k;
                  end
               end
               win.max_value     = best;
               win.max_offset    = mpa_pkg::OFFSET_BITS'(best_off);
               win.max_position  = mpa_pkg::COUNT_BITS'(start + best_off);
               win.window_number = windows_done;
               win.last_window   = eor;
               pending_windows.push_back(win);
               windows_done = windows_done + 1'b1;
               next_start   = start + step;
            end
            row_pos = row_pos + 1;
         end
         // Restart the row after the end word
         if (eor) begin
            row_pos      = 0;
            next_start   = 0;
            windows_done = '0;
         end
      endfunction

      function void check_window(pool_result_type act);
         pool_result_type want;
         if (pending_windows.size() == 0) begin
            $error("window result with none expected: max_value %0d", act.max_value);
            fail_count++;
            return;
         end
         want = pending_windows.pop_front();
         if (act.max_value !== want.max_value) begin
            $error("max_value: expected %0d, actual %0d", want.max_value, act.max_value);
            fail_count++;
         end
         if (act.max_offset !== want.max_offset) begin
            $error("max_offset: expected %0d, actual %0d", want.max_offset, act.max_offset);
            fail_count++;
         end
         if (act.max_position !== want.max_position) begin
            $error("max_position: expected %0d, actual %0d",
                   want.max_position, act.max_position);
            fail_count++;
         end
         if (act.window_number !== want.window_number) begin
            $error("window_number: expected %0d, actual %0d",
                   want.window_number, act.window_number);
            fail_count++;
         end
         if (act.last_window !== want.last_window) begin
            $error("last_window: expected %0d, actual %0d", want.last_window, act.last_window);
            fail_count++;
         end
      endfunction

      function int waiting();
         return pending_windows.size();
      endfunction
   endclass

   logic                                 clock;
   logic                                 reset;
   logic                                 req_push;
   logic                                 req_full;
   logic signed [SAMPLE_W-1:0]           req_sample;
   logic                                 req_end_of_row;
   logic                                 rsp_empty;
   logic                                 rsp_pop;
   logic signed [SAMPLE_W-1:0]           rsp_max_value;
   logic [mpa_pkg::OFFSET_BITS-1:0]      rsp_max_offset;
   logic [mpa_pkg::COUNT_BITS-1:0]       rsp_max_position;
   logic [mpa_pkg::COUNT_BITS-1:0]       rsp_window_number;
   logic                                 rsp_last_window;
   logic                                 csr_valid;
   logic                                 csr_ready;
   logic [mpa_pkg::CSR_INDEX_BITS-1:0]   csr_index;
   logic [mpa_pkg::CSR_DATA_BITS-1:0]    csr_data;

   int send_idle_pct;
   int recv_stall_pct;
   int rsp_hold_left;
   int idle_cycles;

   pool_scoreboard_type board = new();

   max_pool_1d_with_argmax_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_sample        (req_sample),
      .req_end_of_row    (req_end_of_row),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_max_value     (rsp_max_value),
      .rsp_max_offset    (rsp_max_offset),
      .rsp_max_position  (rsp_max_position),
      .rsp_window_number (rsp_window_number),
      .rsp_last_window   (rsp_last_window),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Offer one sample word after a random gap and hold it until taken
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample, input logic eor);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push       <= 1'b1;
      req_sample     <= sample;
      req_end_of_row <= eor;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_sample(sample, eor);
   endtask

   // Write one register; only called with the block idle
   task automatic write_csr(input logic [mpa_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [mpa_pkg::CSR_DATA_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      board.note_setting(idx, data);
      @(posedge clock);
   endtask

   // Stop sending, wait for every expected window, then let the back end go quiet
   task automatic settle();
      req_push <= 1'b0;
      while (board.waiting() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      int sel;
      sel = $urandom_range(7);
      if (sel == 0) return 16'sh7FFF;
      if (sel == 1) return 16'sh8000;
      // Narrow values make ties common
      if (sel < 4) return SAMPLE_W'(int'($urandom_range(4)) - 2);
      return SAMPLE_W'($urandom);
   endfunction

   // Choose window settings, extremes often
   task automatic pick_settings();
      logic [mpa_pkg::CSR_DATA_BITS-1:0] len_data;
      logic [mpa_pkg::CSR_DATA_BITS-1:0] step_data;
      case ($urandom_range(5))
         0: len_data = 8'd0;
         1: len_data = 8'd1;
         2: len_data = 8'd16;
         3: len_data = 8'($urandom_range(17, 31));
         default: len_data = 8'($urandom_range(2, 15));
      endcase
      len_data[7:5] = 3'($urandom);
      case ($urandom_range(5))
         0: step_data = 8'd0;
         1: step_data = 8'd1;
         2: step_data = 8'd255;
         default: step_data = 8'($urandom_range(2, 16));
      endcase
      if ($urandom_range(3) == 0)
         write_csr($urandom_range(1) ? CSR_SPARE_HI : CSR_SPARE_LO, 8'($urandom));
      write_csr(mpa_pkg::CSR_WINDOW_LENGTH, len_data);
      write_csr(mpa_pkg::CSR_WINDOW_STEP, step_data);
   endtask

   // Rows of random content; some cut short by a settings change mid-row
   task automatic run_traffic(input int items);
      int   sent;
      int   row_len;
      logic broken;
      logic eor;
      sent = 0;
      while (sent < items) begin
         row_len = ($urandom_range(9) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
         broken  = ($urandom_range(5) == 0);
         for (int n = 0; n < row_len; n++) begin
            eor = (n == row_len - 1) ? !broken : ($urandom_range(49) == 0);
            send_sample(pick_sample(), eor);
            sent++;
         end
         if (broken || $urandom_range(2) == 0) begin
            settle();
            pick_settings();
         end
      end
   endtask

   // Result side: pop at random, honor a requested hold-off
   initial begin
      pool_result_type act;
      rsp_pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_pop && !rsp_empty) begin
            act.max_value     = rsp_max_value;
            act.max_offset    = rsp_max_offset;
            act.max_position  = rsp_max_position;
            act.window_number = rsp_window_number;
            act.last_window   = rsp_last_window;
            board.check_window(act);
         end
         if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog: end the run if no word moves for too long
   initial begin
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
             (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("FAILURE");
      $finish;
   end

   initial begin
      reset          <= 1'b1;
      req_push       <= 1'b0;
      req_sample     <= '0;
      req_end_of_row <= 1'b0;
      csr_valid      <= 1'b0;
      csr_index      <= '0;
      csr_data       <= '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      rsp_hold_left  = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);

      // Reset settings, length 2 step 2: extremes, a tie, a window closing the row
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sd5, 1'b0);
      send_sample(16'sd5, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sh8000, 1'b1);
      settle();

      // Zero length and zero step both act as one
      write_csr(mpa_pkg::CSR_WINDOW_LENGTH, 8'd0);
      write_csr(mpa_pkg::CSR_WINDOW_STEP, 8'd0);
      send_sample(16'sd0, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sh5555, 1'b1);
      settle();

      // Undecoded indexes, saturated length, widest step, a trailing sample in no window
      write_csr(CSR_SPARE_LO, 8'hA5);
      write_csr(CSR_SPARE_HI, 8'h5A);
      write_csr(mpa_pkg::CSR_WINDOW_LENGTH, 8'hFF);
      write_csr(mpa_pkg::CSR_WINDOW_STEP, 8'hFF);
      for (int k = 0; k < 17; k++)
         send_sample((k == 3 || k == 11) ? 16'sh7FFF : SAMPLE_W'(k - 8), k == 16);
      settle();

      // Random traffic under each idling pattern
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 27; recv_stall_pct = 27; end
         endcase
         settle();
         if (phase == 0) begin
            // Dense windows while the result side holds off, so the input backs up
            write_csr(mpa_pkg::CSR_WINDOW_LENGTH, 8'd2);
            write_csr(mpa_pkg::CSR_WINDOW_STEP, 8'd1);
            rsp_hold_left = HOLD_CYCLES;
         end else begin
            pick_settings();
         end
         run_traffic(RANDOM_ITEMS / 4);
      end

      settle();
      if (board.fail_count == 0 && board.waiting() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
